// ===== sv/dpc_pkg.sv =====
// Shared constants, register indexes and control types of the defect pixel corrector.
`timescale 1ns / 1ps

package dpc_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int PIX_FIELD_W = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int SIZE_W      = 13;

    localparam int ROW_SLOTS = 7;
    localparam int SLOT_W    = 3;
    localparam int WIN       = 5;
    localparam int SEL_W     = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(1920);
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(1080);

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE    = 2'd0,
        CFG_THRESHOLD = 2'd1,
        CFG_WIDTH     = 2'd2,
        CFG_HEIGHT    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                  restart;
        logic                  enable;
        logic [CFG_DATA_W-1:0] threshold;
    } ctrl_t;

endpackage

// ===== sv/dpc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module dpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== sv/dpc_queue.sv =====
// Short request queue between the front and back parts; each entry carries the last-pixel flag.
`timescale 1ns / 1ps

module dpc_queue import dpc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic              push_last,
    input  logic              pop,
    output logic              head_valid,
    output logic              head_last,
    output logic [QCNT_W-1:0] count
);

    logic              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        wptr_next  = push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_last;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_last  = entry_reg[rptr_reg];
    assign count      = count_reg;

endmodule

// ===== sv/dpc_front.sv =====
// Front part: configuration registers, input acceptance, line store writes and output scheduling.
`timescale 1ns / 1ps

module dpc_front import dpc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int AW     = $clog2(MAX_WIDTH),
    localparam int W_BITS = $clog2(MAX_WIDTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_action,
    input  logic [PIX_FIELD_W-1:0] s_pixel_in,
    output logic                   wr_en,
    output logic [SLOT_W-1:0]      wr_slot,
    output logic [AW-1:0]          wr_col,
    output logic [PIXEL_BITS-1:0]  wr_data,
    input  logic [QCNT_W-1:0]      q_count,
    output logic                   q_push,
    output logic                   q_push_last,
    output ctrl_t                  ctrl,
    output logic [W_BITS-1:0]      w_eff,
    output logic [SIZE_W-1:0]      h_eff
);

    localparam int DW = W_BITS + 2;

    logic                  enable_reg, enable_next;
    logic [CFG_DATA_W-1:0] threshold_reg, threshold_next;
    logic [SIZE_W-1:0]     width_reg, width_next;
    logic [SIZE_W-1:0]     height_reg, height_next;
    logic [AW-1:0]         in_col_reg, in_col_next;
    logic [SIZE_W-1:0]     in_row_reg, in_row_next;
    logic [SLOT_W-1:0]     in_slot_reg, in_slot_next;
    logic [AW-1:0]         out_col_reg, out_col_next;
    logic [SIZE_W-1:0]     out_row_reg, out_row_next;
    logic [DW-1:0]         pend_reg, pend_next;
    logic                  received_reg, received_next;

    logic              restart;
    logic              accept;
    logic              take_pixel;
    logic              emit;
    logic              in_col_last;
    logic              out_last;
    logic [DW-1:0]     lag;
    logic [DW-1:0]     pend_plus;
    logic              frame_start;
    logic [QCNT_W-1:0] cap;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = W_BITS'(1);
        end else if (int'(width_reg) > MAX_WIDTH) begin
            w_eff = W_BITS'(MAX_WIDTH);
        end else begin
            w_eff = W_BITS'(width_reg);
        end
        h_eff = (height_reg == '0) ? SIZE_W'(1) : height_reg;
    end

    assign lag         = (DW'(w_eff) << 1) + DW'(2);
    assign frame_start = (in_col_reg == '0) && (in_row_reg == '0) && !received_reg;
    assign cap         = (w_eff == W_BITS'(1)) ? QCNT_W'(1) : QCNT_W'(QUEUE_DEPTH);
    assign s_ready     = (q_count < cap) && !(frame_start && (q_count != '0));
    assign accept      = s_valid && s_ready;
    assign take_pixel  = accept && (s_action == ACT_PIXEL) && !received_reg;
    assign pend_plus   = pend_reg + DW'(1);
    assign emit        = take_pixel ? (pend_plus > lag) : (accept && received_reg);
    assign in_col_last = (W_BITS'(in_col_reg) + W_BITS'(1)) == w_eff;
    assign out_last    = ((W_BITS'(out_col_reg) + W_BITS'(1)) == w_eff)
                         && (out_row_reg == h_eff - SIZE_W'(1));
    assign restart     = cfg_wr_en
                         && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));

    always_comb begin
        enable_next    = enable_reg;
        threshold_next = threshold_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ENABLE:    enable_next    = cfg_data[0];
                CFG_THRESHOLD: threshold_next = cfg_data;
                CFG_WIDTH:     width_next     = cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:    height_next    = cfg_data[SIZE_W-1:0];
                default:       enable_next    = enable_reg;
            endcase
        end
    end

    always_comb begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        in_slot_next  = in_slot_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        received_next = received_reg;
        pend_next     = pend_reg + DW'(take_pixel) - DW'(emit);
        if (take_pixel) begin
            if (in_col_last) begin
                in_col_next = '0;
                if (in_row_reg == h_eff - SIZE_W'(1)) begin
                    in_row_next   = '0;
                    in_slot_next  = '0;
                    received_next = 1'b1;
                end else begin
                    in_row_next  = in_row_reg + SIZE_W'(1);
                    in_slot_next = (in_slot_reg == SLOT_W'(ROW_SLOTS - 1))
                                   ? '0 : in_slot_reg + SLOT_W'(1);
                end
            end else begin
                in_col_next = in_col_reg + AW'(1);
            end
        end
        if (emit) begin
            if (W_BITS'(out_col_reg) + W_BITS'(1) == w_eff) begin
                out_col_next = '0;
                out_row_next = out_row_reg + SIZE_W'(1);
            end else begin
                out_col_next = out_col_reg + AW'(1);
            end
        end
        if (restart || (emit && out_last)) begin
            in_col_next   = '0;
            in_row_next   = '0;
            in_slot_next  = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            received_next = 1'b0;
            pend_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b1;
            threshold_reg <= '0;
            width_reg     <= RESET_WIDTH;
            height_reg    <= RESET_HEIGHT;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            in_slot_reg   <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            pend_reg      <= '0;
            received_reg  <= 1'b0;
        end else begin
            enable_reg    <= enable_next;
            threshold_reg <= threshold_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            in_slot_reg   <= in_slot_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            pend_reg      <= pend_next;
            received_reg  <= received_next;
        end
    end

    assign wr_en          = take_pixel;
    assign wr_slot        = in_slot_reg;
    assign wr_col         = in_col_reg;
    assign wr_data        = s_pixel_in[PIXEL_BITS-1:0];
    assign q_push         = emit;
    assign q_push_last    = out_last;
    assign ctrl.restart   = restart;
    assign ctrl.enable    = enable_reg;
    assign ctrl.threshold = threshold_reg;

endmodule

// ===== sv/dpc_back.sv =====
// Back part: column fetch from the line stores, 5x5 window assembly, defect test and output register.
`timescale 1ns / 1ps

module dpc_back import dpc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int AW     = $clog2(MAX_WIDTH),
    localparam int W_BITS = $clog2(MAX_WIDTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctrl_t                  ctrl,
    input  logic [W_BITS-1:0]      w_eff,
    input  logic [SIZE_W-1:0]      h_eff,
    input  logic                   q_valid,
    input  logic                   q_last,
    output logic                   q_pop,
    output logic                   ram_re,
    output logic [AW-1:0]          ram_raddr,
    input  logic [PIXEL_BITS-1:0]  ram_rdata [ROW_SLOTS],
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PIX_FIELD_W-1:0] m_pixel_out,
    output logic                   m_was_corrected,
    output logic                   m_frame_end
);

    localparam int PB = PIXEL_BITS;
    localparam int GW = PIXEL_BITS + 1;
    localparam logic [1:0] PRIME_DONE = 2'd2;

    logic [1:0]        prime_reg, prime_next;
    logic [AW-1:0]     fcol_reg, fcol_next;
    logic [SIZE_W-1:0] frow_reg, frow_next;
    logic [SLOT_W-1:0] fslot_reg, fslot_next;
    logic [AW-1:0]     ocol_reg, ocol_next;

    logic              adv, prime, pop, fetch;
    logic [SLOT_W-1:0] slot_calc [WIN];
    logic [SEL_W-1:0]  sel_calc [WIN];

    logic              r_valid_reg, r_real_reg, r_last_reg;
    logic [SLOT_W-1:0] r_slot_reg [WIN];
    logic [SEL_W-1:0]  r_sel_reg [WIN];

    logic [PB-1:0] col_reg [WIN][WIN];
    logic [PB-1:0] col_new [WIN][WIN];
    logic [PB-1:0] win_reg [WIN][WIN];
    logic [PB-1:0] win_new [WIN][WIN];
    logic          w_valid_reg, w_last_reg;

    logic          c_valid_reg, c_last_reg, c_near_reg;
    logic [PB-1:0] c_p_reg, c_lo_reg, c_hi_reg;
    logic [GW-1:0] c_grad_reg [4];
    logic [GW-1:0] c_sum_reg [4];

    logic          near_ok;
    logic [PB-1:0] lo_val, hi_val;
    logic [GW-1:0] grad_val [4];
    logic [GW-1:0] sum_val [4];

    logic          defect;
    logic [GW-1:0] pick_sum;

    logic                   m_valid_reg;
    logic [PIX_FIELD_W-1:0] m_pixel_reg;
    logic                   m_fixed_reg, m_end_reg;

    assign adv   = !m_valid_reg || m_ready;
    assign prime = q_valid && (prime_reg != PRIME_DONE) && adv;
    assign pop   = q_valid && (prime_reg == PRIME_DONE) && adv;
    assign fetch = prime || pop;

    always_comb begin
        prime_next = prime_reg;
        fcol_next  = fcol_reg;
        frow_next  = frow_reg;
        fslot_next = fslot_reg;
        ocol_next  = ocol_reg;
        if (prime) begin
            prime_next = prime_reg + 2'd1;
        end
        if (fetch) begin
            if (W_BITS'(fcol_reg) + W_BITS'(1) == w_eff) begin
                fcol_next  = '0;
                frow_next  = frow_reg + SIZE_W'(1);
                fslot_next = (fslot_reg == SLOT_W'(ROW_SLOTS - 1))
                             ? '0 : fslot_reg + SLOT_W'(1);
            end else begin
                fcol_next = fcol_reg + AW'(1);
            end
        end
        if (pop) begin
            if (W_BITS'(ocol_reg) + W_BITS'(1) == w_eff) begin
                ocol_next = '0;
            end else begin
                ocol_next = ocol_reg + AW'(1);
            end
        end
        if (ctrl.restart || (pop && q_last)) begin
            prime_next = '0;
            fcol_next  = '0;
            frow_next  = '0;
            fslot_next = '0;
            ocol_next  = '0;
        end
    end

    always_comb begin
        int rr;
        int off;
        int s;
        int cc;
        for (int i = 0; i < WIN; i++) begin
            rr = int'(frow_reg) + i - 2;
            if (rr < 0) begin
                off = -int'(frow_reg);
            end else if (rr > int'(h_eff) - 1) begin
                off = int'(h_eff) - 1 - int'(frow_reg);
            end else begin
                off = i - 2;
            end
            s = int'(fslot_reg) + off;
            if (s < 0) begin
                s = s + ROW_SLOTS;
            end else if (s >= ROW_SLOTS) begin
                s = s - ROW_SLOTS;
            end
            slot_calc[i] = SLOT_W'(s);
            cc = int'(ocol_reg) + i - 2;
            if (cc < 0) begin
                sel_calc[i] = SEL_W'(2 - int'(ocol_reg));
            end else if (cc > int'(w_eff) - 1) begin
                sel_calc[i] = SEL_W'(1 + int'(w_eff) - int'(ocol_reg));
            end else begin
                sel_calc[i] = SEL_W'(i);
            end
        end
    end

    assign ram_re    = fetch;
    assign ram_raddr = fcol_reg;
    assign q_pop     = pop;

    always_comb begin
        for (int j = 0; j < WIN - 1; j++) begin
            for (int dy = 0; dy < WIN; dy++) begin
                col_new[j][dy] = col_reg[j+1][dy];
            end
        end
        for (int dy = 0; dy < WIN; dy++) begin
            col_new[WIN-1][dy] = ram_rdata[r_slot_reg[dy]];
        end
        for (int dy = 0; dy < WIN; dy++) begin
            for (int dx = 0; dx < WIN; dx++) begin
                win_new[dy][dx] = col_new[r_sel_reg[dx]][dy];
            end
        end
    end

    function automatic logic [PB-1:0] absdiff(input logic [PB-1:0] a, input logic [PB-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [GW-1:0] graddiff(input logic [PB-1:0] p,
                                               input logic [PB-1:0] a,
                                               input logic [PB-1:0] b);
        logic [GW-1:0] twop;
        logic [GW-1:0] sum;
        twop = {p, 1'b0};
        sum  = GW'(a) + GW'(b);
        return (twop > sum) ? twop - sum : sum - twop;
    endfunction

    always_comb begin
        logic [PB-1:0] far_v  [8];
        logic [PB-1:0] near_v [8];
        logic [PB-1:0] p;
        p = win_reg[2][2];
        far_v[0] = win_reg[0][0];
        far_v[1] = win_reg[0][2];
        far_v[2] = win_reg[0][4];
        far_v[3] = win_reg[2][0];
        far_v[4] = win_reg[2][4];
        far_v[5] = win_reg[4][0];
        far_v[6] = win_reg[4][2];
        far_v[7] = win_reg[4][4];
        near_v[0] = win_reg[1][1];
        near_v[1] = win_reg[1][2];
        near_v[2] = win_reg[1][3];
        near_v[3] = win_reg[2][1];
        near_v[4] = win_reg[2][3];
        near_v[5] = win_reg[3][1];
        near_v[6] = win_reg[3][2];
        near_v[7] = win_reg[3][3];
        lo_val  = far_v[0];
        hi_val  = far_v[0];
        near_ok = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (far_v[i] < lo_val) begin
                lo_val = far_v[i];
            end
            if (far_v[i] > hi_val) begin
                hi_val = far_v[i];
            end
            if (CFG_DATA_W'(absdiff(p, near_v[i])) <= ctrl.threshold) begin
                near_ok = 1'b0;
            end
        end
        grad_val[0] = graddiff(p, win_reg[0][2], win_reg[4][2]);
        grad_val[1] = graddiff(p, win_reg[2][0], win_reg[2][4]);
        grad_val[2] = graddiff(p, win_reg[0][0], win_reg[4][4]);
        grad_val[3] = graddiff(p, win_reg[0][4], win_reg[4][0]);
        sum_val[0]  = GW'(win_reg[1][2]) + GW'(win_reg[3][2]);
        sum_val[1]  = GW'(win_reg[2][1]) + GW'(win_reg[2][3]);
        sum_val[2]  = GW'(win_reg[1][1]) + GW'(win_reg[3][3]);
        sum_val[3]  = GW'(win_reg[1][3]) + GW'(win_reg[3][1]);
    end

    always_comb begin
        defect = ctrl.enable && c_near_reg && ((c_p_reg < c_lo_reg) || (c_p_reg > c_hi_reg));
        if ((c_grad_reg[0] <= c_grad_reg[1]) && (c_grad_reg[0] <= c_grad_reg[2])
            && (c_grad_reg[0] <= c_grad_reg[3])) begin
            pick_sum = c_sum_reg[0];
        end else if ((c_grad_reg[1] <= c_grad_reg[2]) && (c_grad_reg[1] <= c_grad_reg[3])) begin
            pick_sum = c_sum_reg[1];
        end else if (c_grad_reg[2] <= c_grad_reg[3]) begin
            pick_sum = c_sum_reg[2];
        end else begin
            pick_sum = c_sum_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_reg   <= '0;
            fcol_reg    <= '0;
            frow_reg    <= '0;
            fslot_reg   <= '0;
            ocol_reg    <= '0;
            r_valid_reg <= 1'b0;
            w_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            prime_reg <= prime_next;
            fcol_reg  <= fcol_next;
            frow_reg  <= frow_next;
            fslot_reg <= fslot_next;
            ocol_reg  <= ocol_next;
            if (adv) begin
                r_valid_reg <= fetch;
                w_valid_reg <= r_valid_reg && r_real_reg;
                c_valid_reg <= w_valid_reg;
                m_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_real_reg <= pop;
            r_last_reg <= q_last;
            r_slot_reg <= slot_calc;
            r_sel_reg  <= sel_calc;
            if (r_valid_reg) begin
                col_reg <= col_new;
            end
            win_reg     <= win_new;
            w_last_reg  <= r_last_reg;
            c_last_reg  <= w_last_reg;
            c_near_reg  <= near_ok;
            c_p_reg     <= win_reg[2][2];
            c_lo_reg    <= lo_val;
            c_hi_reg    <= hi_val;
            c_grad_reg  <= grad_val;
            c_sum_reg   <= sum_val;
            m_pixel_reg <= defect ? PIX_FIELD_W'(pick_sum[GW-1:1]) : PIX_FIELD_W'(c_p_reg);
            m_fixed_reg <= defect;
            m_end_reg   <= c_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_pixel_out     = m_pixel_reg;
    assign m_was_corrected = m_fixed_reg;
    assign m_frame_end     = m_end_reg;

endmodule

// ===== sv/bayer_defect_pixel_correct_unit.sv =====
// Top level of the streaming defect pixel corrector: front part, request queue, line stores, back part.
// Throughput: one request per cycle for widths of two or more unless m_ready stalls the output;
// width one lets only one request wait in the queue. At each frame's start input waits until the
// queue empties, and the back part primes its column fetch before the first pixel is popped.
// Output trails the input stream by 2*width+2 pixels, and flush requests drain the tail.
// Reset: synchronous active-low aresetn clears counters and valid bits; line stores are not cleared.
`timescale 1ns / 1ps

module bayer_defect_pixel_correct_unit import dpc_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_action,
    input  logic [PIX_FIELD_W-1:0] s_pixel_in,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PIX_FIELD_W-1:0] m_pixel_out,
    output logic                   m_was_corrected,
    output logic                   m_frame_end
);

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int W_BITS = $clog2(MAX_WIDTH + 1);

    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_slot;
    logic [AW-1:0]         wr_col;
    logic [PIXEL_BITS-1:0] wr_data;
    logic [QCNT_W-1:0]     q_count;
    logic                  q_push, q_push_last, q_pop, q_valid, q_last;
    ctrl_t                 ctrl;
    logic [W_BITS-1:0]     w_eff;
    logic [SIZE_W-1:0]     h_eff;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [PIXEL_BITS-1:0] ram_rdata [ROW_SLOTS];

    dpc_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_pixel_in (s_pixel_in),
        .wr_en      (wr_en),
        .wr_slot    (wr_slot),
        .wr_col     (wr_col),
        .wr_data    (wr_data),
        .q_count    (q_count),
        .q_push     (q_push),
        .q_push_last(q_push_last),
        .ctrl       (ctrl),
        .w_eff      (w_eff),
        .h_eff      (h_eff)
    );

    dpc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_last (q_push_last),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_last (q_last),
        .count     (q_count)
    );

    for (genvar g = 0; g < ROW_SLOTS; g++) begin : g_line
        dpc_ram #(
            .WIDTH(PIXEL_BITS),
            .DEPTH(MAX_WIDTH)
        ) u_ram (
            .aclk (aclk),
            .we   (wr_en && (wr_slot == SLOT_W'(g))),
            .waddr(wr_col),
            .wdata(wr_data),
            .re   (ram_re),
            .raddr(ram_raddr),
            .rdata(ram_rdata[g])
        );
    end

    dpc_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .w_eff          (w_eff),
        .h_eff          (h_eff),
        .q_valid        (q_valid),
        .q_last         (q_last),
        .q_pop          (q_pop),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_out    (m_pixel_out),
        .m_was_corrected(m_was_corrected),
        .m_frame_end    (m_frame_end)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the streaming defect pixel corrector with its own prediction.
`timescale 1ns / 1ps

module tb_top;
    import dpc_pkg::*;

    typedef struct packed {
        logic [15:0] pixel;
        logic        fixed;
        logic        last;
    } pixel_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_action = ACT_PIXEL;
    logic [PIX_FIELD_W-1:0] s_pixel_in = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [PIX_FIELD_W-1:0] m_pixel_out;
    logic                   m_was_corrected;
    logic                   m_frame_end;

    bayer_defect_pixel_correct_unit u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the corrector state.
    logic [15:0]       shadow_rows [ROW_SLOTS][DEF_MAX_WIDTH];
    logic              sh_enable = 1'b1;
    logic [15:0]       sh_threshold = '0;
    logic [SIZE_W-1:0] sh_width = RESET_WIDTH;
    logic [SIZE_W-1:0] sh_height = RESET_HEIGHT;
    int                in_col, in_row, out_col, out_row;
    bit                frame_done;

    pixel_result_t pending_pixels[$];
    int  errors = 0;
    int  pixels_sent = 0;
    int  results_seen = 0;
    int  corrections_seen = 0;
    int  frames_seen = 0;
    bit  no_gaps = 1'b0;
    int  stall_left = 0;

    function automatic int eff_w();
        if (sh_width < 1) return 1;
        if (sh_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return int'(sh_width);
    endfunction

    function automatic int eff_h();
        return (sh_height < 1) ? 1 : int'(sh_height);
    endfunction

    function automatic int neighbour(int r, int c, int w, int h);
        if (r < 0) r = 0;
        if (r > h - 1) r = h - 1;
        if (c < 0) c = 0;
        if (c > w - 1) c = w - 1;
        return int'(shadow_rows[r % ROW_SLOTS][c]);
    endfunction

    function automatic int absdiff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Advances the shadow state by one accepted request and queues any pixel it releases.
    function automatic void predict_pixel(logic act, logic [15:0] pix);
        int w, h, total, lag, got, p, lo, hi, dv, dh, dd, du, m, sum, res;
        int win[25];
        int far_pos[8];
        int near_pos[8];
        bit emit, defect;
        pixel_result_t r;
        far_pos = '{0, 2, 4, 10, 14, 20, 22, 24};
        near_pos = '{6, 7, 8, 11, 13, 16, 17, 18};
        w = eff_w();
        h = eff_h();
        total = w * h;
        lag = 2 * w + 2;
        if (act == ACT_PIXEL && !frame_done) begin
            shadow_rows[in_row % ROW_SLOTS][in_col] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
                if (in_row >= h) begin
                    in_row = 0;
                    frame_done = 1'b1;
                end
            end
            got = frame_done ? total : in_row * w + in_col;
            emit = got > out_row * w + out_col + lag;
        end else begin
            emit = frame_done;
        end
        if (!emit) return;
        for (int dy = 0; dy < 5; dy++)
            for (int dx = 0; dx < 5; dx++)
                win[dy * 5 + dx] = neighbour(out_row + dy - 2, out_col + dx - 2, w, h);
        p = win[12];
        res = p;
        r.fixed = 1'b0;
        if (sh_enable) begin
            lo = win[far_pos[0]];
            hi = lo;
            for (int i = 1; i < 8; i++) begin
                if (win[far_pos[i]] < lo) lo = win[far_pos[i]];
                if (win[far_pos[i]] > hi) hi = win[far_pos[i]];
            end
            defect = (p < lo) || (p > hi);
            for (int i = 0; i < 8; i++)
                if (absdiff(p, win[near_pos[i]]) <= int'(sh_threshold)) defect = 1'b0;
            if (defect) begin
                dv = absdiff(2 * p, win[2] + win[22]);
                dh = absdiff(2 * p, win[10] + win[14]);
                dd = absdiff(2 * p, win[0] + win[24]);
                du = absdiff(2 * p, win[4] + win[20]);
                m = dv;
                if (dh < m) m = dh;
                if (dd < m) m = dd;
                if (du < m) m = du;
                if (m == dv) sum = win[7] + win[17];
                else if (m == dh) sum = win[11] + win[13];
                else if (m == dd) sum = win[6] + win[18];
                else sum = win[8] + win[16];
                res = sum >> 1;
                r.fixed = 1'b1;
            end
        end
        r.pixel = res[15:0];
        r.last = (out_row * w + out_col + 1 == total);
        pending_pixels.push_back(r);
        if (r.last) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            frame_done = 1'b0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_request(logic act, logic [15:0] pix);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_action   <= act;
        s_pixel_in <= pix;
        do @(posedge aclk); while (!s_ready);
        predict_pixel(act, pix);
        if (act == ACT_PIXEL) pixels_sent++;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        case (idx)
            CFG_ENABLE:    sh_enable = value[0];
            CFG_THRESHOLD: sh_threshold = value;
            default: begin
                if (idx == CFG_WIDTH) sh_width = value[SIZE_W-1:0];
                else sh_height = value[SIZE_W-1:0];
                in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                frame_done = 1'b0;
            end
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic set_frame(logic [15:0] w, logic [15:0] h, logic en, logic [15:0] thr);
        settle();
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_ENABLE, {15'b0, en});
        write_reg(CFG_THRESHOLD, thr);
    endtask

    function automatic logic [15:0] textured(int base);
        int v;
        case ($urandom_range(0, 19))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'($urandom);
            default: begin
                v = base + $urandom_range(0, 64) - 32;
                if (v < 0) v = 0;
                if (v > 65535) v = 65535;
                return v[15:0];
            end
        endcase
    endfunction

    task automatic drain_frame(int extra);
        while (frame_done)
            send_request(($urandom_range(0, 9) == 0) ? ACT_PIXEL : ACT_FLUSH, 16'($urandom));
        repeat (extra) send_request(ACT_FLUSH, 16'($urandom));
    endtask

    task automatic send_textured_frame(int flush_noise);
        int base, n;
        base = $urandom_range(0, 65535);
        n = eff_w() * eff_h();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < flush_noise) send_request(ACT_FLUSH, 16'($urandom));
            send_request(ACT_PIXEL, textured(base));
        end
    endtask

    task automatic test_hot_and_cold_spots();
        logic [15:0] spot [25];
        set_frame(16'd5, 16'd5, 1'b1, 16'd0);
        foreach (spot[i]) spot[i] = 16'd1000 + 16'(i % 3);
        spot[12] = 16'hFFFF;
        spot[6] = 16'h0000;
        spot[18] = 16'd40000;
        spot[0] = 16'hFFFF;
        for (int i = 0; i < 25; i++) send_request(ACT_PIXEL, spot[i]);
        drain_frame(2);
        set_frame(16'd5, 16'd5, 1'b0, 16'd0);
        for (int i = 0; i < 25; i++) send_request(ACT_PIXEL, spot[i]);
        drain_frame(0);
    endtask

    task automatic test_threshold_extremes();
        set_frame(16'd6, 16'd4, 1'b1, 16'hFFFF);
        send_textured_frame(0);
        drain_frame(0);
        set_frame(16'd6, 16'd4, 1'b1, 16'd20);
        send_textured_frame(5);
        drain_frame(1);
    endtask

    task automatic test_size_extremes();
        set_frame(16'd0, 16'd0, 1'b1, 16'd0);
        send_request(ACT_PIXEL, 16'hA5A5);
        send_request(ACT_PIXEL, 16'h5A5A);
        drain_frame(2);
        set_frame(16'hFFFF, 16'd1, 1'b1, 16'd3);
        repeat (40) send_request(ACT_PIXEL, 16'($urandom));
        settle();
        set_frame(16'd1, 16'd300, 1'b1, 16'd3);
        send_textured_frame(0);
        drain_frame(0);
    endtask

    task automatic test_abandoned_frame();
        set_frame(16'd4, 16'd4, 1'b1, 16'd0);
        repeat (7) send_request(ACT_PIXEL, 16'($urandom));
        settle();
        write_reg(CFG_ENABLE, 16'd0);
        write_reg(CFG_ENABLE, 16'd1);
        write_reg(CFG_WIDTH, 16'd3);
        send_textured_frame(0);
        drain_frame(0);
    endtask

    task automatic test_random_frames();
        int w, h;
        while (pixels_sent < 1300) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            h = $urandom_range(1, 8);
            set_frame(16'(w), 16'(h), ($urandom_range(0, 7) != 0),
                      ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200)));
            no_gaps = ($urandom_range(0, 4) == 0);
            send_textured_frame(3);
            drain_frame($urandom_range(0, 2));
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn || no_gaps) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 49) == 0) begin
            stall_left <= $urandom_range(5, 30);
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge aclk) begin
        pixel_result_t exp_px;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_was_corrected) corrections_seen++;
            if (m_frame_end) frames_seen++;
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel %0d with no request outstanding", m_pixel_out);
                errors++;
            end else begin
                exp_px = pending_pixels.pop_front();
                if (m_pixel_out !== exp_px.pixel) begin
                    $error("pixel_out: expected %0d, got %0d", exp_px.pixel, m_pixel_out);
                    errors++;
                end
                if (m_was_corrected !== exp_px.fixed) begin
                    $error("was_corrected: expected %0d, got %0d",
                           exp_px.fixed, m_was_corrected);
                    errors++;
                end
                if (m_frame_end !== exp_px.last) begin
                    $error("frame_end: expected %0d, got %0d", exp_px.last, m_frame_end);
                    errors++;
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("Run timed out with %0d pixels still expected.", pending_pixels.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        foreach (shadow_rows[r, c]) shadow_rows[r][c] = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_hot_and_cold_spots();
        test_threshold_extremes();
        test_size_extremes();
        test_abandoned_frame();
        test_random_frames();
        settle();
        if (pending_pixels.size() != 0) begin
            $error("%0d expected pixels never arrived", pending_pixels.size());
            errors++;
        end
        $display("Sent %0d pixels; checked %0d outputs over %0d frames, %0d of them corrected.",
                 pixels_sent, results_seen, frames_seen, corrections_seen);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
